### rtl/irim_pkg.sv
// Shared constants, types and codes for the image rotation inverse-map block.
`timescale 1ns / 1ps
`default_nettype none
package irim_pkg;

  // Geometry of the source store and the angle format.
  localparam int MAX_DIM        = 512;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int AXIS_W         = $clog2(MAX_DIM);
  localparam int ADDR_W         = 2 * AXIS_W;
  localparam int MEM_DEPTH      = MAX_DIM * MAX_DIM;

  // Field widths of the channels and registers.
  localparam int PIX_W      = 24;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Internal arithmetic widths.
  localparam int DPROD_W  = DIM_W + 1 + TRIG_W;      // dimension times trig value
  localparam int CORNER_W = DPROD_W + 1;             // rotated corner coordinate
  localparam int EXT_W    = CORNER_W + 1;            // corner extent
  localparam int CEIL_W   = EXT_W - TRIG_FRAC_BITS;  // extent in whole pixels
  localparam int POS_W    = CORNER_W + 1;            // offset output position
  localparam int MPROD_W  = POS_W + TRIG_W;          // position times trig value
  localparam int MSUM_W   = MPROD_W + 1;             // sum of two products
  localparam int MAP_W    = MSUM_W - 2 * TRIG_FRAC_BITS;
  localparam int SIZE_MAX = (1 << SIZE_W) - 1;

  // Cycles from a register write until the derived geometry is valid again.
  localparam int SETTLE_CYCLES = 5;
  localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MAPPED     = 2'd0,
    ST_BACKGROUND = 2'd1,
    ST_OUTSIDE    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS   = 2'd0,
    CFG_SIN   = 2'd1,
    CFG_SRC_W = 2'd2,
    CFG_SRC_H = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_MAP,
    BK_OUT
  } back_state_e;

  // Derived geometry, held steady while the block is idle.
  typedef struct packed {
    logic                       settled;
    logic signed [TRIG_W-1:0]   cos_v;
    logic signed [TRIG_W-1:0]   sin_v;
    logic [DIM_W-1:0]           src_w;
    logic [DIM_W-1:0]           src_h;
    logic signed [CORNER_W-1:0] off_x;
    logic signed [CORNER_W-1:0] off_y;
    logic [SIZE_W-1:0]          rot_w;
    logic [SIZE_W-1:0]          rot_h;
  } geom_t;

  // One classified item in the queue.
  typedef struct packed {
    cmd_e                    cmd;
    logic                    load_ok;
    logic                    outside;
    logic [ADDR_W-1:0]       addr;
    logic [PIX_W-1:0]        pixel;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } entry_t;

  // Source memory access from the back.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

### rtl/irim_if.sv
// Handshake channel interfaces for input words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface irim_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [irim_pkg::COORD_W-1:0] coord_x;
  logic [irim_pkg::COORD_W-1:0] coord_y;
  logic [irim_pkg::PIX_W-1:0]   pixel_in;

  modport source (output valid, command, coord_x, coord_y, pixel_in, input ready);
  modport sink (input valid, command, coord_x, coord_y, pixel_in, output ready);
endinterface

interface irim_out_if;
  logic                        valid;
  logic                        ready;
  logic [irim_pkg::PIX_W-1:0]  pixel_out;
  logic [1:0]                  status;
  logic [irim_pkg::SIZE_W-1:0] out_width;
  logic [irim_pkg::SIZE_W-1:0] out_height;

  modport source (output valid, pixel_out, status, out_width, out_height, input ready);
  modport sink (input valid, pixel_out, status, out_width, out_height, output ready);
endinterface
`default_nettype wire

### rtl/irim_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module irim_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/irim_geom.sv
// Configuration registers and the pipelined corner, offset and size computation.
`timescale 1ns / 1ps
`default_nettype none
module irim_geom (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [irim_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [irim_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output irim_pkg::geom_t                    geom_o
);

  logic signed [irim_pkg::TRIG_W-1:0]   cos_q, sin_q;
  logic [irim_pkg::DIM_W-1:0]           src_w_q, src_h_q;
  logic [irim_pkg::DIM_W-1:0]           w_eff, h_eff;
  logic [irim_pkg::SETTLE_W-1:0]        settle_q, settle_d;
  logic signed [irim_pkg::DIM_W:0]      w_s, h_s;
  logic signed [irim_pkg::DPROD_W-1:0]  wc_q, hs_q, hc_q, ws_q;
  logic signed [irim_pkg::CORNER_W-1:0] p1x, p2x, p3x, p1y, p2y, p3y;
  logic signed [irim_pkg::CORNER_W-1:0] p1x_q, p2x_q, p3x_q, p1y_q, p2y_q, p3y_q;
  logic signed [irim_pkg::CORNER_W-1:0] mnx_d, mny_d, mxx_d, mxy_d;
  logic signed [irim_pkg::CORNER_W-1:0] mnx_q, mny_q, mxx_q, mxy_q;
  logic signed [irim_pkg::CORNER_W-1:0] offx_q, offy_q;
  logic [irim_pkg::EXT_W-1:0]           ext_x, ext_y, rnd_x, rnd_y;
  logic [irim_pkg::CEIL_W-1:0]          cx, cy;
  logic [irim_pkg::SIZE_W-1:0]          rotw_q, roth_q, rotw_d, roth_d;

  // Register writes; a write restarts the settle count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= irim_pkg::TRIG_W'(1 << irim_pkg::TRIG_FRAC_BITS);
      sin_q   <= '0;
      src_w_q <= irim_pkg::DIM_W'(irim_pkg::MAX_DIM);
      src_h_q <= irim_pkg::DIM_W'(irim_pkg::MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (irim_pkg::cfg_idx_e'(cfg_idx_i))
        irim_pkg::CFG_COS:   cos_q   <= cfg_wdata_i;
        irim_pkg::CFG_SIN:   sin_q   <= cfg_wdata_i;
        irim_pkg::CFG_SRC_W: src_w_q <= cfg_wdata_i[irim_pkg::DIM_W-1:0];
        irim_pkg::CFG_SRC_H: src_h_q <= cfg_wdata_i[irim_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = irim_pkg::SETTLE_W'(irim_pkg::SETTLE_CYCLES);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= irim_pkg::SETTLE_W'(irim_pkg::SETTLE_CYCLES);
    end else begin
      settle_q <= settle_d;
    end
  end

  // Source size clamped to the store.
  assign w_eff = (src_w_q > irim_pkg::DIM_W'(irim_pkg::MAX_DIM)) ?
                 irim_pkg::DIM_W'(irim_pkg::MAX_DIM) : src_w_q;
  assign h_eff = (src_h_q > irim_pkg::DIM_W'(irim_pkg::MAX_DIM)) ?
                 irim_pkg::DIM_W'(irim_pkg::MAX_DIM) : src_h_q;
  assign w_s = signed'({1'b0, w_eff});
  assign h_s = signed'({1'b0, h_eff});

  // Stage one: the four products of size and angle.
  always_ff @(posedge clk_i) begin
    wc_q <= w_s * cos_q;
    hs_q <= h_s * sin_q;
    hc_q <= h_s * cos_q;
    ws_q <= w_s * sin_q;
  end

  // Stage two: rotated corners other than the origin.
  always_comb begin
    p1x = -irim_pkg::CORNER_W'(hs_q);
    p2x = irim_pkg::CORNER_W'(wc_q) - irim_pkg::CORNER_W'(hs_q);
    p3x = irim_pkg::CORNER_W'(wc_q);
    p1y = irim_pkg::CORNER_W'(hc_q);
    p2y = irim_pkg::CORNER_W'(hc_q) + irim_pkg::CORNER_W'(ws_q);
    p3y = irim_pkg::CORNER_W'(ws_q);
  end

  always_ff @(posedge clk_i) begin
    p1x_q <= p1x;
    p2x_q <= p2x;
    p3x_q <= p3x;
    p1y_q <= p1y;
    p2y_q <= p2y;
    p3y_q <= p3y;
  end

  // Stage three: bounding box, the origin included.
  always_comb begin
    mnx_d = '0;
    mxx_d = '0;
    mny_d = '0;
    mxy_d = '0;
    if (p1x_q < mnx_d) mnx_d = p1x_q;
    if (p2x_q < mnx_d) mnx_d = p2x_q;
    if (p3x_q < mnx_d) mnx_d = p3x_q;
    if (p1x_q > mxx_d) mxx_d = p1x_q;
    if (p2x_q > mxx_d) mxx_d = p2x_q;
    if (p3x_q > mxx_d) mxx_d = p3x_q;
    if (p1y_q < mny_d) mny_d = p1y_q;
    if (p2y_q < mny_d) mny_d = p2y_q;
    if (p3y_q < mny_d) mny_d = p3y_q;
    if (p1y_q > mxy_d) mxy_d = p1y_q;
    if (p2y_q > mxy_d) mxy_d = p2y_q;
    if (p3y_q > mxy_d) mxy_d = p3y_q;
  end

  always_ff @(posedge clk_i) begin
    mnx_q <= mnx_d;
    mny_q <= mny_d;
    mxx_q <= mxx_d;
    mxy_q <= mxy_d;
  end

  // Stage four: extent rounded up to whole pixels, saturated to the size field.
  always_comb begin
    ext_x = irim_pkg::EXT_W'(mxx_q) - irim_pkg::EXT_W'(mnx_q);
    ext_y = irim_pkg::EXT_W'(mxy_q) - irim_pkg::EXT_W'(mny_q);
    rnd_x = ext_x + irim_pkg::EXT_W'((1 << irim_pkg::TRIG_FRAC_BITS) - 1);
    rnd_y = ext_y + irim_pkg::EXT_W'((1 << irim_pkg::TRIG_FRAC_BITS) - 1);
    cx    = rnd_x[irim_pkg::EXT_W-1:irim_pkg::TRIG_FRAC_BITS];
    cy    = rnd_y[irim_pkg::EXT_W-1:irim_pkg::TRIG_FRAC_BITS];
    rotw_d = (cx > irim_pkg::CEIL_W'(irim_pkg::SIZE_MAX)) ?
             irim_pkg::SIZE_W'(irim_pkg::SIZE_MAX) : cx[irim_pkg::SIZE_W-1:0];
    roth_d = (cy > irim_pkg::CEIL_W'(irim_pkg::SIZE_MAX)) ?
             irim_pkg::SIZE_W'(irim_pkg::SIZE_MAX) : cy[irim_pkg::SIZE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    offx_q <= mnx_q;
    offy_q <= mny_q;
    rotw_q <= rotw_d;
    roth_q <= roth_d;
  end

  always_comb begin
    geom_o.settled = (settle_q == '0);
    geom_o.cos_v   = cos_q;
    geom_o.sin_v   = sin_q;
    geom_o.src_w   = w_eff;
    geom_o.src_h   = h_eff;
    geom_o.off_x   = offx_q;
    geom_o.off_y   = offy_q;
    geom_o.rot_w   = rotw_q;
    geom_o.rot_h   = roth_q;
  end

endmodule
`default_nettype wire

### rtl/irim_front.sv
// Front end: accepts input words and classifies them into queue entries.
`timescale 1ns / 1ps
`default_nettype none
module irim_front (
  irim_in_if.sink                in_s,
  input  irim_pkg::geom_t        geom_i,
  input  wire                    full_i,
  output logic                   push_o,
  output irim_pkg::entry_t       entry_o
);

  logic [irim_pkg::POS_W-1:0] x_scaled, y_scaled;

  // Accept while the geometry is valid and the queue has room.
  assign in_s.ready = geom_i.settled && !full_i;
  assign push_o     = in_s.valid && in_s.ready;

  // Output position in sub-pixel units, moved by the bounding box corner.
  assign x_scaled = irim_pkg::POS_W'({in_s.coord_x, {irim_pkg::TRIG_FRAC_BITS{1'b0}}});
  assign y_scaled = irim_pkg::POS_W'({in_s.coord_y, {irim_pkg::TRIG_FRAC_BITS{1'b0}}});

  always_comb begin
    entry_o.cmd     = irim_pkg::cmd_e'(in_s.command);
    entry_o.load_ok = (in_s.coord_x < geom_i.src_w) && (in_s.coord_y < geom_i.src_h);
    entry_o.outside = ({1'b0, in_s.coord_x} >= geom_i.rot_w) ||
                      ({1'b0, in_s.coord_y} >= geom_i.rot_h);
    entry_o.addr    = {in_s.coord_y[irim_pkg::AXIS_W-1:0],
                       in_s.coord_x[irim_pkg::AXIS_W-1:0]};
    entry_o.pixel   = in_s.pixel_in;
    entry_o.pos_x   = signed'(x_scaled) + irim_pkg::POS_W'(geom_i.off_x);
    entry_o.pos_y   = signed'(y_scaled) + irim_pkg::POS_W'(geom_i.off_y);
  end

endmodule
`default_nettype wire

### rtl/irim_fifo.sv
// Short register queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module irim_fifo (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  irim_pkg::entry_t        entry_i,
  output logic                    full_o,
  input  wire                     pop_i,
  output logic                    empty_o,
  output irim_pkg::entry_t        head_o
);

  irim_pkg::entry_t                 slot_q [irim_pkg::FIFO_DEPTH];
  logic [irim_pkg::FIFO_PTR_W-1:0]  wptr_q, rptr_q;
  logic [irim_pkg::FIFO_CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == irim_pkg::FIFO_CNT_W'(irim_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/irim_back.sv
// Back end: executes loads and maps queries back into the source image.
`timescale 1ns / 1ps
`default_nettype none
module irim_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          empty_i,
  input  irim_pkg::entry_t             head_i,
  output logic                         pop_o,
  input  irim_pkg::geom_t              geom_i,
  output irim_pkg::ram_req_t           ram_o,
  input  wire  [irim_pkg::PIX_W-1:0]   ram_rdata_i,
  irim_out_if.source                   out_m
);

  irim_pkg::back_state_e               state_q, state_d;
  irim_pkg::entry_t                    cur_q;
  irim_pkg::status_e                   status_q, status_d;
  logic signed [irim_pkg::MPROD_W-1:0] xc_q, ys_q, yc_q, xs_q;
  logic signed [irim_pkg::MSUM_W-1:0]  sum_x, sum_y, rnd_x, rnd_y;
  logic signed [irim_pkg::MAP_W-1:0]   sx, sy;
  logic                                in_range;
  logic                                out_free;
  logic                                out_load;
  logic                                out_valid_q;
  logic [irim_pkg::PIX_W-1:0]          out_pix_q;
  irim_pkg::status_e                   out_status_q;
  logic [irim_pkg::SIZE_W-1:0]         out_w_q, out_h_q;

  localparam logic [irim_pkg::MSUM_W-1:0] Round =
    {{(irim_pkg::MSUM_W - 2 * irim_pkg::TRIG_FRAC_BITS){1'b0}},
     {(2 * irim_pkg::TRIG_FRAC_BITS){1'b1}}};

  assign out_free = !out_valid_q || out_m.ready;

  // Source coordinates rounded up after the inverse rotation.
  always_comb begin
    sum_x = irim_pkg::MSUM_W'(xc_q) + irim_pkg::MSUM_W'(ys_q);
    sum_y = irim_pkg::MSUM_W'(yc_q) - irim_pkg::MSUM_W'(xs_q);
    rnd_x = sum_x + signed'(Round);
    rnd_y = sum_y + signed'(Round);
    sx    = rnd_x[irim_pkg::MSUM_W-1:2*irim_pkg::TRIG_FRAC_BITS];
    sy    = rnd_y[irim_pkg::MSUM_W-1:2*irim_pkg::TRIG_FRAC_BITS];
    in_range = !sx[irim_pkg::MAP_W-1] && !sy[irim_pkg::MAP_W-1] &&
               (sx[irim_pkg::MAP_W-2:0] < (irim_pkg::MAP_W-1)'(geom_i.src_w)) &&
               (sy[irim_pkg::MAP_W-2:0] < (irim_pkg::MAP_W-1)'(geom_i.src_h));
  end

  // Sequencer: next state, queue pop and memory access.
  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    ram_o.we    = 1'b0;
    ram_o.waddr = head_i.addr;
    ram_o.wdata = head_i.pixel;
    ram_o.re    = 1'b0;
    ram_o.raddr = {sy[irim_pkg::AXIS_W-1:0], sx[irim_pkg::AXIS_W-1:0]};
    unique case (state_q)
      irim_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.cmd == irim_pkg::CMD_QUERY) begin
            state_d = irim_pkg::BK_MUL;
          end else begin
            ram_o.we = head_i.load_ok;
          end
        end
      end
      irim_pkg::BK_MUL: begin
        state_d = irim_pkg::BK_MAP;
      end
      irim_pkg::BK_MAP: begin
        if (cur_q.outside) begin
          status_d = irim_pkg::ST_OUTSIDE;
        end else if (in_range) begin
          status_d = irim_pkg::ST_MAPPED;
          ram_o.re = 1'b1;
        end else begin
          status_d = irim_pkg::ST_BACKGROUND;
        end
        state_d = irim_pkg::BK_OUT;
      end
      irim_pkg::BK_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = irim_pkg::BK_IDLE;
        end
      end
      default: state_d = irim_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irim_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Query payload and the four products of position and angle.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if (state_q == irim_pkg::BK_MUL) begin
      xc_q <= cur_q.pos_x * geom_i.cos_v;
      ys_q <= cur_q.pos_y * geom_i.sin_v;
      yc_q <= cur_q.pos_y * geom_i.cos_v;
      xs_q <= cur_q.pos_x * geom_i.sin_v;
    end
    status_q <= status_d;
  end

  // Output register; it holds a finished word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pix_q    <= (status_q == irim_pkg::ST_MAPPED) ? ram_rdata_i : '0;
      out_status_q <= status_q;
      out_w_q      <= geom_i.rot_w;
      out_h_q      <= geom_i.rot_h;
    end
  end

  assign out_m.valid      = out_valid_q;
  assign out_m.pixel_out  = out_pix_q;
  assign out_m.status     = out_status_q;
  assign out_m.out_width  = out_w_q;
  assign out_m.out_height = out_h_q;

endmodule
`default_nettype wire

### rtl/image_rotate_inverse_map.sv
// Top level of the nearest-neighbor image rotation block with inverse mapping.
//
//   Port         Dir  Contents
//   in_s         in   command, coord_x, coord_y, pixel_in (valid/ready)
//   out_m        out  pixel_out, status, out_width, out_height (valid/ready)
//   cfg_*_i      in   write enable, register index, 16-bit write data
//
// The front accepts one word per cycle into a four-entry queue while it has
// room. The back sequencer retires a load in its pop step and a query in four
// steps (queue pop, multiply, map with memory read, output), and takes no new
// word until a query is past its output step. After reset and after every
// register write, input is held off while the geometry pipeline settles. The
// source memory has no clearing pass. A result waiting in the output register
// does not stop the front, and the back stalls only at its final step.
`timescale 1ns / 1ps
`default_nettype none
module image_rotate_inverse_map (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  irim_in_if.sink                          in_s,
  irim_out_if.source                       out_m,
  input  wire                              cfg_we_i,
  input  wire  [irim_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire  [irim_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  irim_pkg::geom_t             geom;
  irim_pkg::entry_t            push_entry, head_entry;
  irim_pkg::ram_req_t          ram_req;
  logic                        push, pop, full, empty;
  logic [irim_pkg::PIX_W-1:0]  ram_rdata;

  irim_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom)
  );

  irim_front u_front (
    .in_s    (in_s),
    .geom_i  (geom),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  irim_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  irim_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head_entry),
    .pop_o       (pop),
    .geom_i      (geom),
    .ram_o       (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_m       (out_m)
  );

  irim_ram #(
    .WIDTH (irim_pkg::PIX_W),
    .DEPTH (irim_pkg::MEM_DEPTH)
  ) u_src_mem (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire

### sim/tb_image_rotate_inverse_map.sv
// Self-checking testbench for the nearest-neighbor image rotation block.
`timescale 1ns / 1ps
module tb_image_rotate_inverse_map;

  // Run control.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;

  // One input word as offered to the block.
  typedef struct packed {
    irim_pkg::cmd_e               cmd;
    logic [irim_pkg::COORD_W-1:0] x;
    logic [irim_pkg::COORD_W-1:0] y;
    logic [irim_pkg::PIX_W-1:0]   pixel;
  } in_word_t;

  // Predicted answer to one query; addr is the source location when mapped.
  typedef struct packed {
    logic [irim_pkg::PIX_W-1:0]  pixel;
    irim_pkg::status_e           status;
    logic [irim_pkg::SIZE_W-1:0] out_w;
    logic [irim_pkg::SIZE_W-1:0] out_h;
    logic [irim_pkg::ADDR_W-1:0] addr;
  } lookup_t;

  logic clk_i;
  logic rst_ni;
  logic                            cfg_we;
  logic [irim_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [irim_pkg::CFG_DATA_W-1:0] cfg_wdata;

  irim_in_if  in_if ();
  irim_out_if out_if ();

  image_rotate_inverse_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (in_if),
    .out_m       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow copy of the registers and of the source image.
  logic signed [irim_pkg::TRIG_W-1:0] reg_cos;
  logic signed [irim_pkg::TRIG_W-1:0] reg_sin;
  logic [irim_pkg::DIM_W-1:0]         reg_src_w;
  logic [irim_pkg::DIM_W-1:0]         reg_src_h;
  logic [irim_pkg::PIX_W-1:0]         src_image [0:irim_pkg::MEM_DEPTH-1];
  bit                                 planned_wr [0:irim_pkg::MEM_DEPTH-1];

  in_word_t pending_words [$];
  lookup_t  expected_pixels [$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       hold_req;
  bit       hold_done;
  int       hold_left;
  int       quiet_cycles;

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint ceil_shr(longint a, int sh);
    if (a >= 0) return (a + (longint'(1) << sh) - 1) >> sh;
    return -((-a) >> sh);
  endfunction

  function automatic longint min_of4(longint a, longint b, longint c, longint d);
    longint m;
    m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    if (d < m) m = d;
    return m;
  endfunction

  function automatic longint max_of4(longint a, longint b, longint c, longint d);
    longint m;
    m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    if (d > m) m = d;
    return m;
  endfunction

  function automatic longint eff_dim(logic [irim_pkg::DIM_W-1:0] d);
    return (d > irim_pkg::MAX_DIM) ? longint'(irim_pkg::MAX_DIM) : longint'(d);
  endfunction

  // Derive the rotated geometry from the registers and map one output
  // point back to the source. The pixel field is left at zero.
  function automatic lookup_t map_point(longint qx, longint qy);
    longint  c, s, w, h, p1x, p1y, p2x, p2y, p3x, p3y;
    longint  mnx, mny, rw, rh, big_x, big_y, sx, sy;
    lookup_t r;
    c   = longint'(reg_cos);
    s   = longint'(reg_sin);
    w   = eff_dim(reg_src_w);
    h   = eff_dim(reg_src_h);
    p1x = -h * s;
    p1y = h * c;
    p2x = w * c - h * s;
    p2y = h * c + w * s;
    p3x = w * c;
    p3y = w * s;
    mnx = min_of4(0, p1x, p2x, p3x);
    mny = min_of4(0, p1y, p2y, p3y);
    rw  = ceil_shr(max_of4(0, p1x, p2x, p3x) - mnx, irim_pkg::TRIG_FRAC_BITS);
    rh  = ceil_shr(max_of4(0, p1y, p2y, p3y) - mny, irim_pkg::TRIG_FRAC_BITS);
    if (rw < 0) rw = 0;
    if (rw > irim_pkg::SIZE_MAX) rw = irim_pkg::SIZE_MAX;
    if (rh < 0) rh = 0;
    if (rh > irim_pkg::SIZE_MAX) rh = irim_pkg::SIZE_MAX;
    r.pixel = '0;
    r.out_w = rw[irim_pkg::SIZE_W-1:0];
    r.out_h = rh[irim_pkg::SIZE_W-1:0];
    r.addr  = '0;
    if (qx >= rw || qy >= rh) begin
      r.status = irim_pkg::ST_OUTSIDE;
    end else begin
      big_x = (qx << irim_pkg::TRIG_FRAC_BITS) + mnx;
      big_y = (qy << irim_pkg::TRIG_FRAC_BITS) + mny;
      sx = ceil_shr(big_x * c + big_y * s, 2 * irim_pkg::TRIG_FRAC_BITS);
      sy = ceil_shr(big_y * c - big_x * s, 2 * irim_pkg::TRIG_FRAC_BITS);
      if (sx >= 0 && sx < w && sy >= 0 && sy < h) begin
        r.status = irim_pkg::ST_MAPPED;
        r.addr   = irim_pkg::ADDR_W'(sy * irim_pkg::MAX_DIM + sx);
      end else begin
        r.status = irim_pkg::ST_BACKGROUND;
      end
    end
    return r;
  endfunction

  // Update the shadow image or queue the expected pixel for one accepted word.
  function automatic void accept_word(in_word_t wd);
    lookup_t r;
    if (wd.cmd == irim_pkg::CMD_LOAD) begin
      if (wd.x < eff_dim(reg_src_w) && wd.y < eff_dim(reg_src_h))
        src_image[wd.y * irim_pkg::MAX_DIM + wd.x] = wd.pixel;
    end else begin
      r = map_point(wd.x, wd.y);
      if (r.status == irim_pkg::ST_MAPPED) r.pixel = src_image[r.addr];
      expected_pixels.push_back(r);
    end
  endfunction

  task automatic plan_load(int x, int y, logic [irim_pkg::PIX_W-1:0] pix);
    in_word_t wd;
    wd.cmd   = irim_pkg::CMD_LOAD;
    wd.x     = irim_pkg::COORD_W'(x);
    wd.y     = irim_pkg::COORD_W'(y);
    wd.pixel = pix;
    pending_words.push_back(wd);
    if (x < eff_dim(reg_src_w) && y < eff_dim(reg_src_h))
      planned_wr[y * irim_pkg::MAX_DIM + x] = 1'b1;
  endtask

  // A query that maps onto a pixel not yet written gets a load in front of it.
  task automatic plan_query(int x, int y);
    in_word_t wd;
    lookup_t  r;
    r = map_point(x, y);
    if (r.status == irim_pkg::ST_MAPPED && !planned_wr[r.addr])
      plan_load(r.addr % irim_pkg::MAX_DIM, r.addr / irim_pkg::MAX_DIM,
                irim_pkg::PIX_W'($urandom));
    wd.cmd   = irim_pkg::CMD_QUERY;
    wd.x     = irim_pkg::COORD_W'(x);
    wd.y     = irim_pkg::COORD_W'(y);
    wd.pixel = irim_pkg::PIX_W'($urandom);
    pending_words.push_back(wd);
  endtask

  // Random mix: mostly loads inside the source and queries inside the
  // output, with some noise anywhere in the coordinate range. Every queued
  // word counts toward n, the loads put in front of queries too.
  task automatic plan_random(int n);
    lookup_t g;
    int      rw, rh, ew, eh, pick, start_n;
    g  = map_point(0, 0);
    rw = (g.out_w > 1024) ? 1024 : int'(g.out_w);
    rh = (g.out_h > 1024) ? 1024 : int'(g.out_h);
    ew = int'(eff_dim(reg_src_w));
    eh = int'(eff_dim(reg_src_h));
    start_n = pending_words.size();
    while (pending_words.size() - start_n < n) begin
      pick = $urandom_range(99);
      if (pick < 35 && ew > 0 && eh > 0) begin
        plan_load($urandom_range(ew - 1), $urandom_range(eh - 1),
                  irim_pkg::PIX_W'($urandom));
      end else if (pick < 40) begin
        plan_load($urandom_range(1023), $urandom_range(1023), irim_pkg::PIX_W'($urandom));
      end else if (pick < 90 && rw > 0 && rh > 0) begin
        plan_query($urandom_range(rw - 1), $urandom_range(rh - 1));
      end else begin
        plan_query($urandom_range(1023), $urandom_range(1023));
      end
    end
  endtask

  // Idle means nothing queued, nothing offered and no pixel outstanding;
  // the extra cycles let trailing loads retire.
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_if.valid || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(irim_pkg::cfg_idx_e idx, logic [irim_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      irim_pkg::CFG_COS:   reg_cos = value;
      irim_pkg::CFG_SIN:   reg_sin = value;
      irim_pkg::CFG_SRC_W: reg_src_w = value[irim_pkg::DIM_W-1:0];
      irim_pkg::CFG_SRC_H: reg_src_h = value[irim_pkg::DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [15:0] c, logic [15:0] s, int w, int h);
    wait_idle();
    write_reg(irim_pkg::CFG_COS, c);
    write_reg(irim_pkg::CFG_SIN, s);
    write_reg(irim_pkg::CFG_SRC_W, irim_pkg::CFG_DATA_W'(w));
    write_reg(irim_pkg::CFG_SRC_H, irim_pkg::CFG_DATA_W'(h));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(logic [15:0] c, logic [15:0] s, int w, int h, int n);
    set_geometry(c, s, w, h);
    plan_random(n);
  endtask

  // Driver: offers queued words, predicts each word as it is accepted.
  always @(posedge clk_i) begin : drive_words
    logic     fire;
    in_word_t wd;
    fire = in_if.valid && in_if.ready;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (fire) begin
        wd.cmd   = irim_pkg::cmd_e'(in_if.command);
        wd.x     = in_if.coord_x;
        wd.y     = in_if.coord_y;
        wd.pixel = in_if.pixel_in;
        accept_word(wd);
      end
      if (!in_if.valid || fire) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          wd = pending_words.pop_front();
          in_if.valid    <= 1'b1;
          in_if.command  <= wd.cmd;
          in_if.coord_x  <= wd.x;
          in_if.coord_y  <= wd.y;
          in_if.pixel_in <= wd.pixel;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expected pixel
  // and throttles ready, including one long hold-off.
  always @(posedge clk_i) begin : check_results
    lookup_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result word: pixel %h status %0d size %0dx%0d", $time,
                   out_if.pixel_out, out_if.status, out_if.out_width, out_if.out_height);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_if.pixel_out !== want.pixel) begin
            $display("%0t: pixel_out expected %h actual %h", $time, want.pixel,
                     out_if.pixel_out);
            mismatch_count++;
          end
          if (out_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_if.status);
            mismatch_count++;
          end
          if (out_if.out_width !== want.out_w) begin
            $display("%0t: out_width expected %0d actual %0d", $time, want.out_w,
                     out_if.out_width);
            mismatch_count++;
          end
          if (out_if.out_height !== want.out_h) begin
            $display("%0t: out_height expected %0d actual %0d", $time, want.out_h,
                     out_if.out_height);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any handshake or register write.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("image_rotate_inverse_map verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.command   = irim_pkg::CMD_LOAD;
    in_if.coord_x   = '0;
    in_if.coord_y   = '0;
    in_if.pixel_in  = '0;
    out_if.ready    = 1'b0;
    reg_cos         = 16'sd16384;
    reg_sin         = 16'sd0;
    reg_src_w       = 10'd512;
    reg_src_h       = 10'd512;
    mismatch_count  = 0;
    send_idle_pct   = 12;
    recv_idle_pct   = 58;
    hold_req        = 1'b0;
    hold_done       = 1'b0;
    hold_left       = 0;
    quiet_cycles    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity at the reset settings, corners and edges.
    plan_load(0, 0, 24'hFFFFFF);
    plan_load(511, 511, 24'h000000);
    plan_load(511, 0, 24'hA5A5A5);
    plan_load(0, 511, 24'h5A5A5A);
    plan_load(1023, 1023, 24'h123456);
    plan_load(512, 3, 24'h654321);
    plan_load(3, 512, 24'h0F0F0F);
    plan_query(0, 0);
    plan_query(511, 511);
    plan_query(511, 0);
    plan_query(0, 511);
    plan_query(512, 0);
    plan_query(0, 512);
    plan_query(1023, 1023);

    // Directed: zero angle vector gives a zero output size.
    set_geometry(16'd0, 16'd0, 8, 8);
    plan_load(2, 2, 24'hC3C3C3);
    plan_query(0, 0);
    plan_query(3, 3);

    // Directed: zero source width leaves only background.
    set_geometry(16'd11585, 16'd11585, 0, 5);
    plan_load(0, 0, 24'h777777);
    plan_query(0, 0);
    plan_query(1, 1);

    // Directed: trig extremes and a source size above the store limit.
    set_geometry(16'h8000, 16'h7FFF, 1023, 600);
    plan_load(511, 511, 24'h3C3C3C);
    plan_query(0, 0);
    plan_query(700, 300);
    plan_query($urandom_range(1023), $urandom_range(1023));

    // Directed: half turn of a single pixel.
    set_geometry(16'hC000, 16'd0, 1, 1);
    plan_query(0, 0);

    // Random, sender idles lightly and receiver heavily; one long hold.
    run_phase(16'd11585, 16'd11585, 16, 12, 100);
    hold_req = 1'b1;
    run_phase(16'd0, 16'd16384, 7, 9, 100);
    run_phase(irim_pkg::TRIG_W'($urandom_range(32768) - 16384),
              irim_pkg::TRIG_W'($urandom_range(32768) - 16384),
              $urandom_range(24, 1), $urandom_range(24, 1), 100);

    // Random, roles swapped.
    wait_idle();
    send_idle_pct = 58;
    recv_idle_pct = 12;
    run_phase(16'hC000, 16'd0, 512, 512, 100);
    run_phase(irim_pkg::TRIG_W'($urandom_range(32768) - 16384),
              irim_pkg::TRIG_W'($urandom_range(32768) - 16384),
              $urandom_range(20, 1), $urandom_range(20, 1), 100);
    run_phase(16'd0, 16'hC000, 1, 512, 100);

    // Random, no idling on either side.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'd16384, 16'd0, 1, 1, 80);
    run_phase(irim_pkg::TRIG_W'($urandom_range(65535)),
              irim_pkg::TRIG_W'($urandom_range(65535)),
              $urandom_range(32, 1), $urandom_range(32, 1), 90);
    run_phase(16'h7FFF, 16'h8000, 1023, 1023, 80);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("image_rotate_inverse_map verification clean");
    end else begin
      $display("image_rotate_inverse_map verification failed");
    end
    $finish;
  end

endmodule
